// ===== rtl/core/rk4s_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the RK4 linear ODE stepper.
// Depends on nothing; every other file but rk4s_stream_if imports it.
package rk4s_pkg;

  // Fixed data format of the value fields.
  localparam int DATA_W     = 32;
  localparam int ACC_W      = DATA_W + 3;
  localparam int H_W        = 17;
  localparam int CNT_W      = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FORCING_TERM = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_RATE   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT   = CFG_IDX_W'(3);

  // Configuration reset values.
  localparam logic [H_W-1:0]    RST_STEP_SIZE    = H_W'(66);
  localparam logic [DATA_W-1:0] RST_FORCING_TERM = DATA_W'(2108293);
  localparam logic [DATA_W-1:0] RST_DECAY_RATE   = DATA_W'(26214);
  localparam logic [CNT_W-1:0]  RST_STEP_COUNT   = CNT_W'(6000);

  // Divide-by-three unit: one byte of the dividend per cycle.
  localparam int DIV_BITS   = 8;
  localparam int DIV_CYCLES = (ACC_W + DIV_BITS - 1) / DIV_BITS;
  localparam int DIV_W      = DIV_CYCLES * DIV_BITS;
  localparam int DCNT_W     = $clog2(DIV_CYCLES);

  // Microcode program layout.
  localparam int UC_PC_W = 5;
  localparam logic [UC_PC_W-1:0] PC_DIV_INIT = UC_PC_W'(24);
  localparam logic [UC_PC_W-1:0] PC_DIV_STEP = UC_PC_W'(25);
  localparam logic [UC_PC_W-1:0] PC_FINISH   = UC_PC_W'(26);
  localparam logic [UC_PC_W-1:0] PC_REPORT   = UC_PC_W'(27);

  typedef struct packed {
    logic              kind;
    logic [DATA_W-1:0] start_x;
    logic [DATA_W-1:0] start_y;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] x_value;
    logic [DATA_W-1:0] y_value;
    logic              done_res;
    logic              overflow;
  } out_item_t;

  typedef enum logic [3:0] {
    UOP_MUL_D,
    UOP_MUL_H,
    UOP_RND,
    UOP_SUB,
    UOP_ACC,
    UOP_DIV_INIT,
    UOP_DIV_STEP,
    UOP_FINISH,
    UOP_REPORT
  } uop_e;

  // One control word of the sequencer program.
  typedef struct packed {
    uop_e               op;
    logic               dbl;     // add the slope twice into the weighted sum
    logic               halve;   // next probe point uses half the slope
    logic               jmp;     // jump while the divider has bytes left
    logic [UC_PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic   en;
    logic   start;
    logic   load;
    ucode_t uc;
  } dp_ctrl_t;

  typedef struct packed {
    logic div_more;
    logic ov;
  } dp_stat_t;

  typedef struct packed {
    logic              ov;
    logic [DATA_W-1:0] val;
  } sat_t;

  localparam ucode_t UW_MUL_D = '{op: UOP_MUL_D, dbl: 1'b0, halve: 1'b0, jmp: 1'b0, target: '0};
  localparam ucode_t UW_MUL_H = '{op: UOP_MUL_H, dbl: 1'b0, halve: 1'b0, jmp: 1'b0, target: '0};
  localparam ucode_t UW_RND   = '{op: UOP_RND,   dbl: 1'b0, halve: 1'b0, jmp: 1'b0, target: '0};
  localparam ucode_t UW_SUB   = '{op: UOP_SUB,   dbl: 1'b0, halve: 1'b0, jmp: 1'b0, target: '0};
  localparam ucode_t UW_ACC1  = '{op: UOP_ACC,   dbl: 1'b0, halve: 1'b1, jmp: 1'b0, target: '0};
  localparam ucode_t UW_ACC2  = '{op: UOP_ACC,   dbl: 1'b1, halve: 1'b1, jmp: 1'b0, target: '0};
  localparam ucode_t UW_ACC3  = '{op: UOP_ACC,   dbl: 1'b1, halve: 1'b0, jmp: 1'b0, target: '0};
  localparam ucode_t UW_ACC4  = '{op: UOP_ACC,   dbl: 1'b0, halve: 1'b0, jmp: 1'b0, target: '0};
  localparam ucode_t UW_DIVI  = '{op: UOP_DIV_INIT, dbl: 1'b0, halve: 1'b0, jmp: 1'b0,
                                  target: '0};
  localparam ucode_t UW_DIVS  = '{op: UOP_DIV_STEP, dbl: 1'b0, halve: 1'b0, jmp: 1'b1,
                                  target: PC_DIV_STEP};
  localparam ucode_t UW_FIN   = '{op: UOP_FINISH, dbl: 1'b0, halve: 1'b0, jmp: 1'b0, target: '0};
  localparam ucode_t UW_REP   = '{op: UOP_REPORT, dbl: 1'b0, halve: 1'b0, jmp: 1'b0, target: '0};

  // Program ROM. Each slope takes six words: d*v, round, g-p, h*f, round, accumulate.
  function automatic ucode_t ucode_fetch(input logic [UC_PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      5'd0, 5'd6, 5'd12, 5'd18: w = UW_MUL_D;
      5'd1, 5'd7, 5'd13, 5'd19: w = UW_RND;
      5'd2, 5'd8, 5'd14, 5'd20: w = UW_SUB;
      5'd3, 5'd9, 5'd15, 5'd21: w = UW_MUL_H;
      5'd4, 5'd10, 5'd16, 5'd22: w = UW_RND;
      5'd5:  w = UW_ACC1;
      5'd11: w = UW_ACC2;
      5'd17: w = UW_ACC3;
      5'd23: w = UW_ACC4;
      PC_DIV_INIT: w = UW_DIVI;
      PC_DIV_STEP: w = UW_DIVS;
      PC_FINISH:   w = UW_FIN;
      default:     w = UW_REP;
    endcase
    return w;
  endfunction

  // Saturate a value with two guard bits to the data width.
  function automatic sat_t sat_dw(input logic [DATA_W+1:0] v);
    sat_t s;
    if (v[DATA_W+1:DATA_W-1] == '0 || v[DATA_W+1:DATA_W-1] == '1) begin
      s.ov  = 1'b0;
      s.val = v[DATA_W-1:0];
    end else begin
      s.ov  = 1'b1;
      s.val = v[DATA_W+1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end
    return s;
  endfunction

  // Magnitude of a signed data word; the most negative value maps to 2^(DATA_W-1).
  function automatic logic [DATA_W-1:0] mag_dw(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
  endfunction

  // Sign extension by two guard bits.
  function automatic logic [DATA_W+1:0] sx2(input logic [DATA_W-1:0] v);
    return {{2{v[DATA_W-1]}}, v};
  endfunction

endpackage

// ===== rtl/core/rk4s_stream_if.sv =====
`timescale 1ns / 1ps
// Valid/ready stream channel carrying one payload struct per transaction.
// The payload type is set by the instance; no other dependencies.
interface rk4s_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/rk4_linear_ode_stepper.sv =====
`timescale 1ns / 1ps
// RK4 stepper for dy/dx = g - d*y: a step transaction runs a 28-word microcode program
// on one shared multiplier; no new item is taken until its result has been reported.
// The four slopes come first, then the divide by six, one byte per cycle.
// Load transactions and steps past the count skip straight to the report word.
// Reset clears x, y and the step counter and restores the configuration defaults.
module rk4_linear_ode_stepper
  import rk4s_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rk4s_stream_if.sink           in_i,
  rk4s_stream_if.source         out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Configuration registers.
  logic [H_W-1:0]    step_size_q;
  logic [DATA_W-1:0] forcing_term_q, decay_rate_q;
  logic [CNT_W-1:0]  step_count_q;

  // Sequencer and result register.
  logic               busy_q;
  logic [UC_PC_W-1:0] pc_q, pc_d;
  logic [CNT_W-1:0]   steps_q;
  logic               out_valid_q;
  out_item_t          out_q;

  ucode_t            uc;
  dp_ctrl_t          ctrl;
  dp_stat_t          stat;
  logic              accept, report, in_range;
  logic [DATA_W-1:0] x_cur, y_cur;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_size_q    <= RST_STEP_SIZE;
      forcing_term_q <= RST_FORCING_TERM;
      decay_rate_q   <= RST_DECAY_RATE;
      step_count_q   <= RST_STEP_COUNT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STEP_SIZE:    step_size_q    <= cfg_data_i[H_W-1:0];
        CFG_FORCING_TERM: forcing_term_q <= cfg_data_i[DATA_W-1:0];
        CFG_DECAY_RATE:   decay_rate_q   <= cfg_data_i[DATA_W-1:0];
        CFG_STEP_COUNT:   step_count_q   <= cfg_data_i[CNT_W-1:0];
        default: begin
          step_size_q <= step_size_q;
        end
      endcase
    end
  end

  // Handshake and microcode fetch.
  assign in_i.ready = !busy_q;
  assign accept     = in_i.valid && !busy_q;
  assign in_range   = (steps_q < step_count_q);
  assign uc         = ucode_fetch(pc_q);
  assign report     = busy_q && (uc.op == UOP_REPORT) && (!out_valid_q || out_o.ready);

  assign ctrl.en    = busy_q && (uc.op != UOP_REPORT);
  assign ctrl.start = accept;
  assign ctrl.load  = !in_i.data.kind;
  assign ctrl.uc    = uc;

  // Program counter: a step in range runs the whole program, anything else only reports.
  always_comb begin
    pc_d = pc_q;
    if (accept) begin
      pc_d = (in_i.data.kind && in_range) ? '0 : PC_REPORT;
    end else if (ctrl.en) begin
      pc_d = (uc.jmp && stat.div_more) ? uc.target : pc_q + UC_PC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= '0;
      steps_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (report) begin
        busy_q <= 1'b0;
      end
      if (accept && !in_i.data.kind) begin
        steps_q <= '0;
      end else if (ctrl.en && uc.op == UOP_FINISH) begin
        steps_q <= steps_q + CNT_W'(1);
      end
      if (report) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload, captured when the program reports.
  always_ff @(posedge clk_i) begin
    if (report) begin
      out_q.x_value  <= x_cur;
      out_q.y_value  <= y_cur;
      out_q.done_res <= (steps_q >= step_count_q);
      out_q.overflow <= stat.ov;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  rk4s_datapath #(
    .FRAC_BITS(FRAC_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .start_x_i     (in_i.data.start_x),
    .start_y_i     (in_i.data.start_y),
    .step_size_i   (step_size_q),
    .forcing_term_i(forcing_term_q),
    .decay_rate_i  (decay_rate_q),
    .stat_o        (stat),
    .x_o           (x_cur),
    .y_o           (y_cur)
  );

endmodule

// ===== rtl/core/rk4s_datapath.sv =====
`timescale 1ns / 1ps
// Arithmetic datapath of the RK4 stepper: shared multiplier, rounding, saturating
// adders, slope accumulator and a byte-serial divide by three. Uses rk4s_pkg.
module rk4s_datapath
  import rk4s_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_ctrl_t          ctrl_i,
  input  logic [DATA_W-1:0] start_x_i,
  input  logic [DATA_W-1:0] start_y_i,
  input  logic [H_W-1:0]    step_size_i,
  input  logic [DATA_W-1:0] forcing_term_i,
  input  logic [DATA_W-1:0] decay_rate_i,
  output dp_stat_t          stat_o,
  output logic [DATA_W-1:0] x_o,
  output logic [DATA_W-1:0] y_o
);

  localparam int PW = 2 * DATA_W;
  localparam logic [PW:0] RND_HALF = (PW + 1)'(1) << (FRAC_BITS - 1);
  localparam logic [PW:0] MAG_LIM  = (PW + 1)'(1) << (DATA_W - 1);

  // Architectural state.
  logic [DATA_W-1:0] x_q, x_d, y_q, y_d;
  logic              ov_q, ov_d;
  logic [DCNT_W-1:0] dcnt_q, dcnt_d;

  // Working registers.
  logic [PW-1:0]     prod_q, prod_d;
  logic              pneg_q, pneg_d;
  logic [DATA_W-1:0] r_q, r_d, f_q, f_d, v_q, v_d;
  logic [ACC_W-1:0]  s_q, s_d;
  logic [DIV_W-1:0]  work_q, work_d;
  logic [1:0]        rem_q, rem_d;
  logic              sneg_q, sneg_d;

  // Combinational helpers.
  logic [DATA_W-1:0] mag_a, mag_b;
  logic              neg_a, neg_b;
  logic [PW:0]       rsum, rq;
  logic [DATA_W-1:0] rnd_val;
  logic              rnd_ov;
  sat_t              sub_s, probe_s, y_s, x_s;
  logic [DATA_W-1:0] kx;
  logic [ACC_W-1:0]  kadd, smag;
  logic [ACC_W:0]    nplus;
  logic [2:0]        dr;
  logic [DIV_W-1:0]  dw;
  logic [DATA_W+1:0] dsgn;

  // Operand selection for the shared multiplier.
  always_comb begin
    if (ctrl_i.uc.op == UOP_MUL_H) begin
      mag_a = DATA_W'(step_size_i);
      neg_a = 1'b0;
      mag_b = mag_dw(f_q);
      neg_b = f_q[DATA_W-1];
    end else begin
      mag_a = mag_dw(decay_rate_i);
      neg_a = decay_rate_i[DATA_W-1];
      mag_b = mag_dw(v_q);
      neg_b = v_q[DATA_W-1];
    end
  end

  // Round the product to nearest, ties away from zero, and saturate.
  always_comb begin
    rsum = {1'b0, prod_q} + RND_HALF;
    rq   = rsum >> FRAC_BITS;
    if (rq >= MAG_LIM) begin
      rnd_val = pneg_q ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      rnd_ov  = pneg_q ? (rq != MAG_LIM) : 1'b1;
    end else begin
      rnd_val = pneg_q ? (~rq[DATA_W-1:0] + DATA_W'(1)) : rq[DATA_W-1:0];
      rnd_ov  = 1'b0;
    end
  end

  // Derivative, next probe point, slope sum and final update.
  always_comb begin
    sub_s   = sat_dw(sx2(forcing_term_i) - sx2(r_q));
    kx      = ctrl_i.uc.halve ? {r_q[DATA_W-1], r_q[DATA_W-1:1]} : r_q;
    probe_s = sat_dw(sx2(y_q) + sx2(kx));
    kadd    = ctrl_i.uc.dbl ? {{2{r_q[DATA_W-1]}}, r_q, 1'b0} : {{3{r_q[DATA_W-1]}}, r_q};
    smag    = s_q[ACC_W-1] ? (~s_q + ACC_W'(1)) : s_q;
    nplus   = {1'b0, smag} + (ACC_W + 1)'(3);
    dsgn    = sneg_q ? (~{1'b0, work_q[DATA_W:0]} + (DATA_W + 2)'(1))
                     : {1'b0, work_q[DATA_W:0]};
    y_s     = sat_dw(sx2(y_q) + dsgn);
    x_s     = sat_dw(sx2(x_q) + (DATA_W + 2)'(step_size_i));
  end

  // One byte of restoring division by three, most significant bit first.
  always_comb begin
    dr = {1'b0, rem_q};
    dw = work_q;
    for (int i = 0; i < DIV_BITS; i++) begin
      dr = {dr[1:0], dw[DIV_W-1]};
      dw = {dw[DIV_W-2:0], 1'b0};
      if (dr >= 3'd3) begin
        dr    = dr - 3'd3;
        dw[0] = 1'b1;
      end
    end
  end

  // Next-state selection by micro-operation.
  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    ov_d   = ov_q;
    dcnt_d = dcnt_q;
    prod_d = prod_q;
    pneg_d = pneg_q;
    r_d    = r_q;
    f_d    = f_q;
    v_d    = v_q;
    s_d    = s_q;
    work_d = work_q;
    rem_d  = rem_q;
    sneg_d = sneg_q;
    if (ctrl_i.start) begin
      ov_d = 1'b0;
      s_d  = '0;
      v_d  = y_q;
      if (ctrl_i.load) begin
        x_d = start_x_i;
        y_d = start_y_i;
      end
    end else if (ctrl_i.en) begin
      case (ctrl_i.uc.op)
        UOP_MUL_D, UOP_MUL_H: begin
          prod_d = mag_a * mag_b;
          pneg_d = neg_a ^ neg_b;
        end
        UOP_RND: begin
          r_d  = rnd_val;
          ov_d = ov_q | rnd_ov;
        end
        UOP_SUB: begin
          f_d  = sub_s.val;
          ov_d = ov_q | sub_s.ov;
        end
        UOP_ACC: begin
          s_d  = s_q + kadd;
          v_d  = probe_s.val;
          // The last slope feeds no further probe point, so its sum never flags.
          ov_d = ov_q | (probe_s.ov & (ctrl_i.uc.halve | ctrl_i.uc.dbl));
        end
        UOP_DIV_INIT: begin
          work_d = DIV_W'(nplus[ACC_W:1]);
          rem_d  = 2'd0;
          sneg_d = s_q[ACC_W-1];
          dcnt_d = '0;
        end
        UOP_DIV_STEP: begin
          work_d = dw;
          rem_d  = dr[1:0];
          dcnt_d = dcnt_q + DCNT_W'(1);
        end
        UOP_FINISH: begin
          y_d  = y_s.val;
          x_d  = x_s.val;
          ov_d = ov_q | y_s.ov | x_s.ov;
        end
        default: begin
          ov_d = ov_q;
        end
      endcase
    end
  end

  // State and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q    <= '0;
      y_q    <= '0;
      ov_q   <= 1'b0;
      dcnt_q <= '0;
    end else begin
      x_q    <= x_d;
      y_q    <= y_d;
      ov_q   <= ov_d;
      dcnt_q <= dcnt_d;
    end
  end

  // Working registers carry payload only.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    pneg_q <= pneg_d;
    r_q    <= r_d;
    f_q    <= f_d;
    v_q    <= v_d;
    s_q    <= s_d;
    work_q <= work_d;
    rem_q  <= rem_d;
    sneg_q <= sneg_d;
  end

  assign stat_o.div_more = (dcnt_q != DCNT_W'(DIV_CYCLES - 1));
  assign stat_o.ov       = ov_q;
  assign x_o             = x_q;
  assign y_o             = y_q;

endmodule

// ===== tb/rk4s_tb_pkg.sv =====
`timescale 1ns / 1ps
// Item kind codes and Q16.16 extremes shared by the stepper testbench and its checker.
// Depends on rk4s_pkg for the data width.
package rk4s_tb_pkg;
  import rk4s_pkg::*;

  // Kind field of an input transaction.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  // Largest and smallest signed data words.
  localparam logic [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};
endpackage

// ===== tb/rk4s_checker.sv =====
`timescale 1ns / 1ps
// Checker for the RK4 stepper: tracks register writes, predicts every result in fixed point
// and compares each result transaction in order. Depends on rk4s_pkg and rk4s_tb_pkg.
module rk4s_checker
  import rk4s_pkg::*;
  import rk4s_tb_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  input  logic                  req_ready_i,
  input  in_item_t              req_data_i,
  input  logic                  res_valid_i,
  input  logic                  res_ready_i,
  input  out_item_t             res_data_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    pending_o,
  output int                    mismatches_o
);

  // Register copies and integrator state; values as 64-bit signed, counts as 32-bit unsigned.
  longint      h_step;
  longint      g_force;
  longint      d_decay;
  int unsigned n_limit;
  longint      pos_x;
  longint      pos_y;
  int unsigned taken;
  bit          clipped;

  out_item_t   predicted_points[$];
  out_item_t   want;
  int          errors;

  // Saturate to a signed width; flags the step when it clips.
  function automatic longint clip(input longint v, input int w);
    longint top_v;
    longint bot_v;
    top_v = (longint'(1) <<< (w - 1)) - 1;
    bot_v = -top_v - 1;
    if (v > top_v) begin
      clipped = 1'b1;
      return top_v;
    end
    if (v < bot_v) begin
      clipped = 1'b1;
      return bot_v;
    end
    return v;
  endfunction

  // Fixed-point product, rounded to nearest with ties away from zero, then saturated.
  function automatic longint qmul(input longint a, input longint b);
    longint          prod;
    longint unsigned mag;
    longint unsigned q;
    longint unsigned lim;
    bit              neg;
    prod = a * b;
    neg  = (a < 0) != (b < 0);
    mag  = (prod < 0) ? -prod : prod;
    q    = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    lim  = 64'd1 << (DATA_W - 1);
    if (neg) begin
      if (q > lim) clipped = 1'b1;
      return (q >= lim) ? -longint'(lim) : -longint'(q);
    end
    if (q >= lim) begin
      clipped = 1'b1;
      return longint'(lim) - 1;
    end
    return longint'(q);
  endfunction

  // Derivative g - d*v.
  function automatic longint slope(input longint v);
    return clip(g_force - qmul(d_decay, v), DATA_W);
  endfunction

  // Apply one input transaction to the state and return the result it should give.
  function automatic out_item_t integrate_item(input in_item_t it);
    out_item_t       r;
    longint          k1, k2, k3, k4, acc, dy;
    longint unsigned mag, q;
    clipped = 1'b0;
    if (it.kind == KIND_LOAD) begin
      pos_x = longint'($signed(it.start_x));
      pos_y = longint'($signed(it.start_y));
      taken = 0;
    end else if (taken < n_limit) begin
      k1  = qmul(h_step, slope(pos_y));
      k2  = qmul(h_step, slope(clip(pos_y + (k1 >>> 1), DATA_W)));
      k3  = qmul(h_step, slope(clip(pos_y + (k2 >>> 1), DATA_W)));
      k4  = qmul(h_step, slope(clip(pos_y + k3, DATA_W)));
      acc = k1;
      acc = clip(acc + k2, ACC_W);
      acc = clip(acc + k2, ACC_W);
      acc = clip(acc + k3, ACC_W);
      acc = clip(acc + k3, ACC_W);
      acc = clip(acc + k4, ACC_W);
      // Divide the weighted sum by six, rounding the magnitude half away from zero.
      mag = (acc < 0) ? -acc : acc;
      q   = mag / 6 + (((mag % 6) >= 3) ? 1 : 0);
      dy  = (acc < 0) ? -longint'(q) : longint'(q);
      pos_y = clip(pos_y + dy, DATA_W);
      pos_x = clip(pos_x + h_step, DATA_W);
      taken = (taken + 1) & 32'hFFFF;
    end
    r.x_value  = DATA_W'(pos_x);
    r.y_value  = DATA_W'(pos_y);
    r.done_res = (taken >= n_limit);
    r.overflow = clipped;
    return r;
  endfunction

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_v);
    errors++;
    $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, exp_v);
  endtask

  // Track registers, predict on accepted requests, compare on accepted results.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_step  = longint'(RST_STEP_SIZE);
      g_force = longint'($signed(RST_FORCING_TERM));
      d_decay = longint'($signed(RST_DECAY_RATE));
      n_limit = 32'(RST_STEP_COUNT);
      pos_x   = 0;
      pos_y   = 0;
      taken   = 0;
      predicted_points.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_STEP_SIZE:    h_step  = longint'(cfg_data_i[H_W-1:0]);
          CFG_FORCING_TERM: g_force = longint'($signed(cfg_data_i[DATA_W-1:0]));
          CFG_DECAY_RATE:   d_decay = longint'($signed(cfg_data_i[DATA_W-1:0]));
          CFG_STEP_COUNT:   n_limit = 32'(cfg_data_i[CNT_W-1:0]);
          default: ;
        endcase
      end
      if (res_valid_i && res_ready_i) begin
        if (predicted_points.size() == 0) begin
          report_mismatch("result with no transaction outstanding", res_data_i.x_value, '0);
        end else begin
          want = predicted_points.pop_front();
          if (res_data_i.x_value !== want.x_value)
            report_mismatch("x_value", res_data_i.x_value, want.x_value);
          if (res_data_i.y_value !== want.y_value)
            report_mismatch("y_value", res_data_i.y_value, want.y_value);
          if (res_data_i.done_res !== want.done_res)
            report_mismatch("done_res", 32'(res_data_i.done_res), 32'(want.done_res));
          if (res_data_i.overflow !== want.overflow)
            report_mismatch("overflow", 32'(res_data_i.overflow), 32'(want.overflow));
        end
      end
      if (req_valid_i && req_ready_i) begin
        predicted_points.push_back(integrate_item(req_data_i));
      end
      pending_o    <= predicted_points.size();
      mismatches_o <= errors;
    end
  end

endmodule

// ===== tb/tb_rk4_linear_ode_stepper.sv =====
`timescale 1ns / 1ps
// Top of the RK4 stepper testbench: clock, reset, register programming and stimulus.
// Depends on rk4s_pkg, rk4s_tb_pkg, rk4s_stream_if, rk4s_checker and the stepper itself.
module tb_rk4_linear_ode_stepper;
  import rk4s_pkg::*;
  import rk4s_tb_pkg::*;

  localparam int FRAC_BITS    = 16;
  localparam int CLK_HALF     = 6;
  localparam int RANDOM_ITEMS = 1750;
  localparam int TAIL_CYCLES  = 40;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    pending;
  int                    mismatches;
  int                    src_idle_pct;
  int                    sink_idle_pct;
  int                    items_sent;

  rk4s_stream_if #(.T(in_item_t))  req_ch ();
  rk4s_stream_if #(.T(out_item_t)) res_ch ();

  rk4_linear_ode_stepper #(
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (req_ch),
    .out_o      (res_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  rk4s_checker #(
    .FRAC_BITS (FRAC_BITS)
  ) u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_valid_i  (req_ch.valid),
    .req_ready_i  (req_ch.ready),
    .req_data_i   (req_ch.data),
    .res_valid_i  (res_ch.valid),
    .res_ready_i  (res_ch.ready),
    .res_data_i   (res_ch.data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .mismatches_o (mismatches)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Result receiver: stalls at random according to the current idle rate.
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Watchdog for a hung run.
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  // Mixed random Q16.16 value: extremes, zero, all ones, full range, small and moderate magnitudes.
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return '0;
      3:       return '1;
      4, 5:    return $urandom();
      6:       return DATA_W'($urandom_range(0, 32'h0020_0000)) - DATA_W'(32'h0010_0000);
      default: return DATA_W'($urandom_range(0, 32'h0800_0000)) - DATA_W'(32'h0400_0000);
    endcase
  endfunction

  function automatic logic [H_W-1:0] pick_step_size();
    case ($urandom_range(9))
      0:       return '0;
      1:       return H_W'(32'h1_0000);
      2:       return H_W'($urandom_range(32'h1_0000, 32'h1_FFFF));
      3, 4, 5: return H_W'($urandom_range(1, 4096));
      default: return H_W'($urandom_range(0, 32'h1_0000));
    endcase
  endfunction

  // Mostly short runs so that the step limit is reached often.
  function automatic logic [CNT_W-1:0] pick_count();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return CNT_W'($urandom_range(1, 12));
    endcase
  endfunction

  // One request transaction, with random idle cycles in front of it.
  task automatic send_item(input logic kind_v, input logic [DATA_W-1:0] x0,
                           input logic [DATA_W-1:0] y0);
    in_item_t item;
    item.kind    = kind_v;
    item.start_x = x0;
    item.start_y = y0;
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= item;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
  endtask

  task automatic send_load(input logic [DATA_W-1:0] x0, input logic [DATA_W-1:0] y0);
    send_item(KIND_LOAD, x0, y0);
  endtask

  // Step transactions carry random start fields, which the block ignores.
  task automatic send_step();
    send_item(KIND_STEP, $urandom(), $urandom());
  endtask

  // Stop sending and wait until every outstanding result has come back.
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // Program all four registers, plus a write to an unmapped index that must be ignored.
  task automatic program_regs(input logic [H_W-1:0] h, input logic [DATA_W-1:0] g,
                              input logic [DATA_W-1:0] d, input logic [CNT_W-1:0] n);
    write_reg(CFG_STEP_SIZE, CFG_DATA_W'(h));
    write_reg(CFG_FORCING_TERM, CFG_DATA_W'(g));
    write_reg(CFG_DECAY_RATE, CFG_DATA_W'(d));
    write_reg(CFG_STEP_COUNT, CFG_DATA_W'(n));
    write_reg(CFG_IDX_W'($urandom_range(CFG_STEP_COUNT + 1, (1 << CFG_IDX_W) - 1)), $urandom());
    cfg_we <= 1'b0;
  endtask

  // Random settings, each followed by load-then-step runs and some random noise items.
  task automatic random_phase(input int quota);
    int stop_at;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      settle();
      program_regs(pick_step_size(), pick_value(), pick_value(), pick_count());
      repeat ($urandom_range(3, 8)) begin
        if ($urandom_range(9) == 0) begin
          send_item(1'($urandom()), $urandom(), $urandom());
        end else begin
          send_load(pick_value(), pick_value());
          repeat ($urandom_range(1, 14)) send_step();
        end
      end
    end
  endtask

  // Main sequence.
  initial begin
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= '0;
    cfg_data     <= '0;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    src_idle_pct  = 7;
    sink_idle_pct = 86;
    items_sent    = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: a step from the cleared state, then loads at zero and both extremes.
    send_step();
    send_load('0, '0);
    send_step();
    send_step();
    send_load(Q_MAX, Q_MAX);
    send_step();
    send_load(Q_MIN, Q_MIN);
    send_step();

    // Unit step, extreme coefficients, two steps allowed then steps past the limit.
    settle();
    program_regs(H_W'(32'h1_0000), Q_MAX, Q_MIN, CNT_W'(2));
    send_load('1, Q_MAX);
    send_step();
    send_step();
    send_step();
    send_load(DATA_W'(1), Q_MIN);
    send_step();

    // Step size above one with the coefficient signs swapped.
    settle();
    program_regs('1, Q_MIN, Q_MAX, CNT_W'(1));
    send_load('0, Q_MAX);
    send_step();
    send_step();

    // Zero step count: a load already reports done and no step moves the state.
    settle();
    program_regs('0, '0, '0, '0);
    send_load(32'h1234_5678, 32'h89AB_CDEF);
    send_step();

    random_phase(RANDOM_ITEMS / 3);

    src_idle_pct  = 86;
    sink_idle_pct = 7;
    random_phase(RANDOM_ITEMS / 3);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    random_phase(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
